[rtl/core/icseq_pkg.sv]
package icseq_pkg;

    // Action codes of an input item
    localparam logic [1:0] ACT_BEGIN_WRITE = 2'd0;
    localparam logic [1:0] ACT_BEGIN_READ  = 2'd1;
    localparam logic [1:0] ACT_BUS_DONE    = 2'd2;

    // R/W bit of the address byte
    localparam logic RW_WRITE = 1'b0;
    localparam logic RW_READ  = 1'b1;

    // Transaction step, one-hot
    typedef enum logic [9:0] {
        PH_IDLE  = 10'b00_0000_0001,
        PH_ADDRW = 10'b00_0000_0010,
        PH_REG   = 10'b00_0000_0100,
        PH_WDATA = 10'b00_0000_1000,
        PH_WNEXT = 10'b00_0001_0000,
        PH_RPT   = 10'b00_0010_0000,
        PH_ADDRR = 10'b00_0100_0000,
        PH_RECV  = 10'b00_1000_0000,
        PH_ACK   = 10'b01_0000_0000,
        PH_STOP  = 10'b10_0000_0000
    } t_phase;

    // Commands to the byte-level bus engine
    typedef enum logic [2:0] {
        CMD_START = 3'd0,
        CMD_SEND  = 3'd1,
        CMD_RPT   = 3'd2,
        CMD_RCEN  = 3'd3,
        CMD_ACK   = 3'd4,
        CMD_STOP  = 3'd5
    } t_cmd;

    // Sequencer state
    typedef struct packed {
        t_phase      phase;
        logic        is_read;
        logic [7:0]  bytes_done;
        logic [7:0]  bytes_wanted;
        logic [6:0]  target_address;
        logic [7:0]  target_register;
    } t_state;

    // One result item
    typedef struct packed {
        t_cmd        command;
        logic [7:0]  tx_byte;
        logic        nack;
        logic [7:0]  rx_byte;
        logic        rx_valid;
        logic [7:0]  byte_position;
        logic        done_res;
    } t_result;

    localparam t_result RESULT_NONE = '{
        command:       CMD_START,
        tx_byte:       8'd0,
        nack:          1'b0,
        rx_byte:       8'd0,
        rx_valid:      1'b0,
        byte_position: 8'd0,
        done_res:      1'b0
    };

endpackage

[rtl/core/icseq_step.sv]
module icseq_step (
    input  icseq_pkg::t_state  i_state,
    input  logic [1:0]         i_action,
    input  logic [6:0]         i_device_address,
    input  logic [7:0]         i_register_index,
    input  logic [7:0]         i_byte_count,
    input  logic [7:0]         i_bus_byte,
    output icseq_pkg::t_state  o_state,
    output icseq_pkg::t_result o_result,
    output logic               o_has_result
);
    import icseq_pkg::*;

    logic [7:0] addr_w;
    logic [7:0] addr_r;
    logic       last;

    assign addr_w = {i_state.target_address, RW_WRITE};
    assign addr_r = {i_state.target_address, RW_READ};
    assign last   = (i_state.bytes_done == i_state.bytes_wanted);

    // Next state and result for one item
    always_comb begin
        o_state      = i_state;
        o_result     = RESULT_NONE;
        o_has_result = 1'b0;

        if (i_action == ACT_BEGIN_WRITE || i_action == ACT_BEGIN_READ) begin
            // begin is dropped while a transaction runs
            if (i_state.phase == PH_IDLE) begin
                o_state.is_read         = (i_action == ACT_BEGIN_READ);
                o_state.target_address  = i_device_address;
                o_state.target_register = i_register_index;
                o_state.bytes_wanted    = i_byte_count;
                o_state.bytes_done      = 8'd0;
                o_state.phase           = PH_ADDRW;
                o_result.command        = CMD_START;
                o_has_result            = 1'b1;
            end
        end else if (i_action == ACT_BUS_DONE) begin
            o_has_result = 1'b1;
            unique case (i_state.phase)
                PH_ADDRW: begin
                    o_result.command = CMD_SEND;
                    o_result.tx_byte = addr_w;
                    o_state.phase    = PH_REG;
                end
                PH_REG: begin
                    o_result.command = CMD_SEND;
                    o_result.tx_byte = i_state.target_register;
                    o_state.phase    = i_state.is_read ? PH_RPT : PH_WDATA;
                end
                PH_WDATA, PH_WNEXT: begin
                    if (i_state.phase == PH_WNEXT && last) begin
                        o_result.command  = CMD_STOP;
                        o_result.done_res = 1'b1;
                        o_state.phase     = PH_IDLE;
                    end else begin
                        o_result.command       = CMD_SEND;
                        o_result.tx_byte       = i_bus_byte;
                        o_result.byte_position = i_state.bytes_done;
                        o_state.bytes_done     = i_state.bytes_done + 8'd1;
                        o_state.phase          = PH_WNEXT;
                    end
                end
                PH_RPT: begin
                    o_result.command = CMD_RPT;
                    o_state.phase    = PH_ADDRR;
                end
                PH_ADDRR: begin
                    o_result.command = CMD_SEND;
                    o_result.tx_byte = addr_r;
                    o_state.phase    = PH_RECV;
                end
                PH_RECV: begin
                    o_result.command   = CMD_RCEN;
                    o_state.bytes_done = i_state.bytes_done + 8'd1;
                    o_state.phase      = PH_ACK;
                end
                PH_ACK: begin
                    o_result.command       = CMD_ACK;
                    o_result.nack          = last;
                    o_result.rx_byte       = i_bus_byte;
                    o_result.rx_valid      = 1'b1;
                    o_result.byte_position = i_state.bytes_done - 8'd1;
                    o_state.phase          = last ? PH_STOP : PH_RECV;
                end
                PH_STOP: begin
                    o_result.command  = CMD_STOP;
                    o_result.done_res = 1'b1;
                    o_state.phase     = PH_IDLE;
                end
                default: begin
                    // done event while idle: no result
                    o_has_result  = 1'b0;
                    o_state.phase = PH_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/icseq_out_reg.sv]
module icseq_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  logic               i_has_result,
    input  icseq_pkg::t_result i_result,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output icseq_pkg::t_result o_result
);
    import icseq_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Room for a new item when empty or draining this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = i_has_result;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset
    always_ff @(posedge i_clk) begin
        if (i_load && i_has_result) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

[rtl/core/i2c_register_transaction_sequencer.sv]
// I2C register transaction sequencer: a begin item (write or read) issues a start command,
// and every bus-done item after it issues the next command of the transaction to the
// byte-level bus engine, through stop. One item is accepted every cycle while the result
// register has room; it is decoded against the sequencer state in a single pass and
// its command, if any, lands in the result register, which also holds a result while the
// downstream side stalls. Input ready drops only while that register is full and not being
// taken. Begin items during a transaction, done items while idle and action code 3 yield
// no command. A byte count of 0 transfers 256 bytes.
module i2c_register_transaction_sequencer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_action,
    input  logic [6:0] i_device_address,
    input  logic [7:0] i_register_index,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_bus_byte,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [2:0] o_command,
    output logic [7:0] o_tx_byte,
    output logic       o_nack,
    output logic [7:0] o_rx_byte,
    output logic       o_rx_valid,
    output logic [7:0] o_byte_position,
    output logic       o_done_res
);
    import icseq_pkg::*;

    t_state  r_state;
    t_state  n_state;
    t_result step_result;
    t_result out_result;
    logic    step_has_result;
    logic    out_free;
    logic    accept;

    assign o_ready = out_free;
    assign accept  = i_valid && out_free;

    // Decode one item
    icseq_step u_step (
        .i_state          (r_state),
        .i_action         (i_action),
        .i_device_address (i_device_address),
        .i_register_index (i_register_index),
        .i_byte_count     (i_byte_count),
        .i_bus_byte       (i_bus_byte),
        .o_state          (n_state),
        .o_result         (step_result),
        .o_has_result     (step_has_result)
    );

    // Sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase           <= PH_IDLE;
            r_state.is_read         <= 1'b0;
            r_state.bytes_done      <= 8'd0;
            r_state.bytes_wanted    <= 8'd0;
            r_state.target_address  <= 7'd0;
            r_state.target_register <= 8'd0;
        end else if (accept) begin
            r_state <= n_state;
        end
    end

    // Result register
    icseq_out_reg u_out_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (accept),
        .i_has_result (step_has_result),
        .i_result     (step_result),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_free       (out_free),
        .o_result     (out_result)
    );

    assign o_command       = out_result.command;
    assign o_tx_byte       = out_result.tx_byte;
    assign o_nack          = out_result.nack;
    assign o_rx_byte       = out_result.rx_byte;
    assign o_rx_valid      = out_result.rx_valid;
    assign o_byte_position = out_result.byte_position;
    assign o_done_res      = out_result.done_res;

endmodule

[test/icseq_command_checker.sv]
`timescale 1ns / 1ps

module icseq_command_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [1:0] i_action,
    input  logic [6:0] i_device_address,
    input  logic [7:0] i_register_index,
    input  logic [7:0] i_byte_count,
    input  logic [7:0] i_bus_byte,
    // result channel
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [2:0] i_command,
    input  logic [7:0] i_tx_byte,
    input  logic       i_nack,
    input  logic [7:0] i_rx_byte,
    input  logic       i_rx_valid,
    input  logic [7:0] i_byte_position,
    input  logic       i_done_res,
    // status to the testbench top
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);
    import icseq_pkg::*;

    // Shadow copy of the sequencer state
    t_phase     seq_phase;
    logic       seq_is_read;
    logic [7:0] seq_bytes_done;
    logic [7:0] seq_bytes_wanted;
    logic [6:0] seq_address;
    logic [7:0] seq_register;

    // Commands still owed by the block, oldest first
    t_result    expected_commands[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Works out the command an item causes and advances the shadow state.
    // Returns 0 when the item is ignored.
    function automatic bit predict_command(
        input  logic [1:0] action,
        input  logic [6:0] addr,
        input  logic [7:0] reg_idx,
        input  logic [7:0] count,
        input  logic [7:0] bus_byte,
        output t_result    cmd
    );
        logic last;
        cmd = RESULT_NONE;
        if (action == ACT_BEGIN_WRITE || action == ACT_BEGIN_READ) begin
            // begin while busy is dropped
            if (seq_phase != PH_IDLE)
                return 1'b0;
            seq_is_read      = (action == ACT_BEGIN_READ);
            seq_address      = addr;
            seq_register     = reg_idx;
            seq_bytes_wanted = count;
            seq_bytes_done   = 8'd0;
            seq_phase        = PH_ADDRW;
            cmd.command      = CMD_START;
            return 1'b1;
        end
        if (action != ACT_BUS_DONE)
            return 1'b0;

        case (seq_phase)
            PH_ADDRW: begin
                cmd.command = CMD_SEND;
                cmd.tx_byte = {seq_address, RW_WRITE};
                seq_phase   = PH_REG;
            end
            PH_REG: begin
                cmd.command = CMD_SEND;
                cmd.tx_byte = seq_register;
                seq_phase   = seq_is_read ? PH_RPT : PH_WDATA;
            end
            PH_WDATA, PH_WNEXT: begin
                // counter wraps, so a count of 0 runs 256 bytes
                if (seq_phase == PH_WNEXT && seq_bytes_done == seq_bytes_wanted) begin
                    cmd.command  = CMD_STOP;
                    cmd.done_res = 1'b1;
                    seq_phase    = PH_IDLE;
                end else begin
                    cmd.command       = CMD_SEND;
                    cmd.tx_byte       = bus_byte;
                    cmd.byte_position = seq_bytes_done;
                    seq_bytes_done    = seq_bytes_done + 8'd1;
                    seq_phase         = PH_WNEXT;
                end
            end
            PH_RPT: begin
                cmd.command = CMD_RPT;
                seq_phase   = PH_ADDRR;
            end
            PH_ADDRR: begin
                cmd.command = CMD_SEND;
                cmd.tx_byte = {seq_address, RW_READ};
                seq_phase   = PH_RECV;
            end
            PH_RECV: begin
                cmd.command    = CMD_RCEN;
                seq_bytes_done = seq_bytes_done + 8'd1;
                seq_phase      = PH_ACK;
            end
            PH_ACK: begin
                last              = (seq_bytes_done == seq_bytes_wanted);
                cmd.command       = CMD_ACK;
                cmd.nack          = last;
                cmd.rx_byte       = bus_byte;
                cmd.rx_valid      = 1'b1;
                cmd.byte_position = seq_bytes_done - 8'd1;
                seq_phase         = last ? PH_STOP : PH_RECV;
            end
            PH_STOP: begin
                cmd.command  = CMD_STOP;
                cmd.done_res = 1'b1;
                seq_phase    = PH_IDLE;
            end
            default: begin
                // done event while idle
                seq_phase = PH_IDLE;
                return 1'b0;
            end
        endcase
        return 1'b1;
    endfunction

    // Counts a failure; only the first few are printed
    task automatic note_mismatch(input string what, input int want, input int got);
        if (o_fail_count < 10)
            $display("mismatch on result %0d, %s: expected %0d, got %0d",
                     o_checked, what, want, got);
        o_fail_count++;
    endtask

    // Compare accepted results, then predict from accepted items
    always @(posedge i_clk) begin : monitor
        t_result want;
        t_result next_cmd;
        if (!i_rst_n) begin
            seq_phase        = PH_IDLE;
            seq_is_read      = 1'b0;
            seq_bytes_done   = 8'd0;
            seq_bytes_wanted = 8'd0;
            seq_address      = 7'd0;
            seq_register     = 8'd0;
            expected_commands.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (expected_commands.size() == 0) begin
                    note_mismatch("unexpected result, command", -1, int'(i_command));
                end else begin
                    want = expected_commands.pop_front();
                    if (i_command != want.command)
                        note_mismatch("command", int'(want.command), int'(i_command));
                    if (i_tx_byte != want.tx_byte)
                        note_mismatch("tx_byte", int'(want.tx_byte), int'(i_tx_byte));
                    if (i_nack != want.nack)
                        note_mismatch("nack", int'(want.nack), int'(i_nack));
                    if (i_rx_byte != want.rx_byte)
                        note_mismatch("rx_byte", int'(want.rx_byte), int'(i_rx_byte));
                    if (i_rx_valid != want.rx_valid)
                        note_mismatch("rx_valid", int'(want.rx_valid), int'(i_rx_valid));
                    if (i_byte_position != want.byte_position)
                        note_mismatch("byte_position", int'(want.byte_position),
                                      int'(i_byte_position));
                    if (i_done_res != want.done_res)
                        note_mismatch("done_res", int'(want.done_res), int'(i_done_res));
                end
                o_checked++;
            end
            if (i_in_valid && i_in_ready) begin
                if (predict_command(i_action, i_device_address, i_register_index,
                                    i_byte_count, i_bus_byte, next_cmd))
                    expected_commands.push_back(next_cmd);
            end
        end
        o_pending = expected_commands.size();
    end

endmodule

[test/i2c_register_transaction_sequencer_tb.sv]
`timescale 1ns / 1ps

module i2c_register_transaction_sequencer_tb;
    import icseq_pkg::*;

    localparam logic [1:0] ACT_RESERVED = 2'd3;
    localparam int ITEM_TARGET     = 1450;
    localparam int HOLD_OFF_CYCLES = 400;

    logic       clk   = 1'b0;
    logic       rst_n = 1'b0;

    logic       in_valid          = 1'b0;
    logic       in_ready;
    logic [1:0] in_action         = ACT_BUS_DONE;
    logic [6:0] in_device_address = 7'd0;
    logic [7:0] in_register_index = 8'd0;
    logic [7:0] in_byte_count     = 8'd0;
    logic [7:0] in_bus_byte       = 8'd0;

    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [2:0] out_command;
    logic [7:0] out_tx_byte;
    logic       out_nack;
    logic [7:0] out_rx_byte;
    logic       out_rx_valid;
    logic [7:0] out_byte_position;
    logic       out_done_res;

    int         fail_count;
    int         pending;
    int         checked;

    // Stimulus bookkeeping
    int         burst_left     = 1;
    int         sequence_items = 0;
    int         noise_items    = 0;
    int         writes         = 0;
    int         reads          = 0;
    bit         hold_off_req   = 1'b0;
    bit         hold_off_done  = 1'b0;

    always #5 clk = ~clk;

    i2c_register_transaction_sequencer uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_valid         (in_valid),
        .o_ready         (in_ready),
        .i_action        (in_action),
        .i_device_address(in_device_address),
        .i_register_index(in_register_index),
        .i_byte_count    (in_byte_count),
        .i_bus_byte      (in_bus_byte),
        .o_valid         (out_valid),
        .i_ready         (out_ready),
        .o_command       (out_command),
        .o_tx_byte       (out_tx_byte),
        .o_nack          (out_nack),
        .o_rx_byte       (out_rx_byte),
        .o_rx_valid      (out_rx_valid),
        .o_byte_position (out_byte_position),
        .o_done_res      (out_done_res)
    );

    icseq_command_checker checker_inst (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_in_valid      (in_valid),
        .i_in_ready      (in_ready),
        .i_action        (in_action),
        .i_device_address(in_device_address),
        .i_register_index(in_register_index),
        .i_byte_count    (in_byte_count),
        .i_bus_byte      (in_bus_byte),
        .i_out_valid     (out_valid),
        .i_out_ready     (out_ready),
        .i_command       (out_command),
        .i_tx_byte       (out_tx_byte),
        .i_nack          (out_nack),
        .i_rx_byte       (out_rx_byte),
        .i_rx_valid      (out_rx_valid),
        .i_byte_position (out_byte_position),
        .i_done_res      (out_done_res),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    // Offer one item, hold it until taken, then maybe pause between bursts
    task automatic send_item(
        input logic [1:0] act,
        input logic [6:0] addr,
        input logic [7:0] reg_idx,
        input logic [7:0] count,
        input logic [7:0] bus_byte
    );
        int gap;
        in_valid          <= 1'b1;
        in_action         <= act;
        in_device_address <= addr;
        in_register_index <= reg_idx;
        in_byte_count     <= count;
        in_bus_byte       <= bus_byte;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 50);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // An item the block should drop: begin or reserved code while busy,
    // done or reserved code while idle
    task automatic send_noise(input bit busy);
        logic [1:0] act;
        if (busy)
            act = ($urandom_range(0, 2) == 0) ? ACT_RESERVED :
                  ($urandom_range(0, 1) == 1) ? ACT_BEGIN_READ : ACT_BEGIN_WRITE;
        else
            act = ($urandom_range(0, 1) == 1) ? ACT_BUS_DONE : ACT_RESERVED;
        send_item(act, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        noise_items++;
    endtask

    // One full transaction: begin, then every done event through stop.
    // fill < 0 gives random bus bytes, else that fixed byte.
    task automatic run_transaction(
        input bit         read_txn,
        input logic [6:0] addr,
        input logic [7:0] reg_idx,
        input logic [7:0] count,
        input int         fill,
        input int         noise_pct
    );
        int n;
        int steps;
        n     = (count == 8'd0) ? 256 : int'(count);
        steps = read_txn ? 2 * n + 5 : n + 3;
        send_item(read_txn ? ACT_BEGIN_READ : ACT_BEGIN_WRITE, addr, reg_idx, count,
                  8'($urandom_range(0, 255)));
        for (int s = 0; s < steps; s++) begin
            if ($urandom_range(0, 99) < noise_pct)
                send_noise(1'b1);
            send_item(ACT_BUS_DONE, 7'($urandom_range(0, 127)), 8'($urandom_range(0, 255)),
                      8'($urandom_range(0, 255)),
                      (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
        end
        sequence_items += steps + 1;
        if (read_txn)
            reads++;
        else
            writes++;
    endtask

    // Stimulus
    initial begin : stimulus
        int sel;
        int txn_index;
        bit read_txn;
        logic [7:0] count;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: ignored items while idle
        send_item(ACT_BUS_DONE, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
        send_item(ACT_RESERVED, 7'h00, 8'h00, 8'h00, 8'h00);
        noise_items += 2;

        // directed: single-byte write at the top address, begins dropped while busy
        send_item(ACT_BEGIN_WRITE, 7'h7F, 8'hFF, 8'd1, 8'h00);
        send_item(ACT_BEGIN_READ, 7'h00, 8'h00, 8'h00, 8'h00);
        send_item(ACT_RESERVED, 7'h7F, 8'hFF, 8'hFF, 8'hFF);
        noise_items += 2;
        repeat (4) send_item(ACT_BUS_DONE, 7'h00, 8'h00, 8'h00, 8'hFF);
        sequence_items += 5;
        writes++;

        // directed: two-byte read at address zero, then a short write
        run_transaction(1'b1, 7'h00, 8'h00, 8'd2, 8'h00, 0);
        run_transaction(1'b0, 7'h2A, 8'h55, 8'd2, -1, 0);

        // random: mostly short transactions, one full 256-byte transfer
        hold_off_req = 1'b1;
        txn_index    = 0;
        while (sequence_items < ITEM_TARGET) begin
            read_txn = ($urandom_range(0, 1) == 1);
            sel      = $urandom_range(0, 99);
            if (txn_index == 2)
                count = 8'd0;
            else if (sel < 82)
                count = 8'($urandom_range(1, 6));
            else if (sel < 97)
                count = 8'($urandom_range(7, 40));
            else
                count = 8'($urandom_range(64, 191));
            if ($urandom_range(0, 99) < 15)
                send_noise(1'b0);
            run_transaction(read_txn, 7'($urandom_range(0, 127)),
                            8'($urandom_range(0, 255)), count, -1, 5);
            txn_index++;
        end
        in_valid <= 1'b0;

        // drain, then a few quiet cycles
        do @(negedge clk); while (pending != 0);
        repeat (20) @(negedge clk);

        $display("covered %0d sequence items (%0d writes, %0d reads, one 256-byte run)",
                 sequence_items, writes, reads);
        $display("plus %0d dropped items; %0d commands checked; one %0d-cycle sink hold-off",
                 noise_items, checked, HOLD_OFF_CYCLES);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Result sink: changing stall patterns, plus one long hold-off
    initial begin : sink
        int mode;
        int span;
        int beat;
        beat = 0;
        @(posedge clk);
        forever begin
            if (hold_off_req && !hold_off_done) begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end else begin
                mode = $urandom_range(0, 3);
                span = $urandom_range(10, 200);
                repeat (span) begin
                    case (mode)
                        0: out_ready <= 1'b1;
                        1: out_ready <= ($urandom_range(0, 1) == 1);
                        2: out_ready <= ($urandom_range(0, 3) == 0);
                        default: out_ready <= ((beat % 10) >= 3);
                    endcase
                    beat++;
                    @(posedge clk);
                end
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/core/icseq_pkg.sv
rtl/core/icseq_step.sv
rtl/core/icseq_out_reg.sv
rtl/core/i2c_register_transaction_sequencer.sv
test/icseq_command_checker.sv
test/i2c_register_transaction_sequencer_tb.sv
